[hw/rtl/three_axis_shake_detector_top_assert.svh]
// Assertion macros shared by the shake detector RTL.
`ifndef THREE_AXIS_SHAKE_DETECTOR_TOP_ASSERT_SVH
`define THREE_AXIS_SHAKE_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHK_ASSERT(lbl, clk, rst, prop, msg)
`define SHK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/shk_pkg.sv]
`default_nettype none
package shk_pkg;

  localparam int AXES      = 3;
  localparam int NORM_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int CNT_W     = $clog2(FRAC_BITS + 1);

  localparam logic signed [15:0] REST_X_RST    = -16'sd86;
  localparam logic signed [15:0] REST_Y_RST    = 16'sd200;
  localparam logic signed [15:0] REST_Z_RST    = 16'sd16500;
  localparam logic        [15:0] THRESHOLD_RST = 16'd16384;
  localparam logic        [15:0] DEBOUNCE_RST  = 16'd500;

  typedef enum logic [2:0] {
    CFG_REST_X,
    CFG_REST_Y,
    CFG_REST_Z,
    CFG_THRESHOLD,
    CFG_DEBOUNCE
  } shk_cfg_idx_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_DIV,
    L_SIGN,
    L_EVAL
  } shk_lane_state_t;

  typedef enum logic {
    T_IDLE,
    T_RUN
  } shk_top_state_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] debounce;
  } shk_eval_cfg_t;

  typedef struct packed {
    logic done;
    logic hit;
  } shk_lane_stat_t;

endpackage
`default_nettype wire

[hw/rtl/shk_lane.sv]
`default_nettype none
`include "three_axis_shake_detector_top_assert.svh"
module shk_lane (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [15:0]     raw,
  input  logic signed [15:0]     rest,
  input  logic        [31:0]     now,
  input  shk_pkg::shk_eval_cfg_t ecfg,
  output shk_pkg::shk_lane_stat_t stat,
  output logic signed [15:0]     norm
);
  import shk_pkg::*;

  shk_lane_state_t state, state_next;

  logic [CNT_W-1:0]  cnt;
  logic [15:0]       rem;
  logic [16:0]       den;
  logic [15:0]       quo;
  logic              neg;
  logic              zero;
  logic              done;
  logic              hit;
  logic signed [15:0] prev;
  logic [31:0]       last;

  logic              ge;
  logic signed [16:0] d;
  logic signed [16:0] nd;
  logic [15:0]       mag0;
  logic signed [17:0] rest_w;
  logic signed [17:0] den_hi;
  logic signed [17:0] den_lo;
  logic [16:0]       den0;
  logic [16:0]       sub0;
  logic              i0;
  logic [16:0]       t;
  logic [16:0]       t_sub;
  logic              take;
  logic signed [16:0] diff;
  logic [16:0]       dmag;
  logic [31:0]       elapsed;
  logic              fire;

  assign ge     = raw >= rest;
  assign d      = {raw[15], raw} - {rest[15], rest};
  assign nd     = -d;
  assign mag0   = ge ? d[15:0] : nd[15:0];
  assign rest_w = 18'(rest);
  assign den_hi = 18'sd32768 - rest_w;
  assign den_lo = rest_w + 18'sd32768;
  assign den0   = ge ? den_hi[16:0] : den_lo[16:0];
  assign sub0   = {1'b0, mag0} - den0;
  assign i0     = {1'b0, mag0} >= den0;

  assign t      = {rem, 1'b0};
  assign t_sub  = t - den;
  assign take   = t >= den;

  assign diff    = {norm[15], norm} - {prev[15], prev};
  assign dmag    = diff[16] ? 17'(-diff) : diff;
  assign elapsed = now - last;
  assign fire    = (dmag > {1'b0, ecfg.threshold}) && (elapsed > {16'd0, ecfg.debounce});

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: begin
        if (start) state_next = L_DIV;
      end
      L_DIV: begin
        if (cnt == CNT_W'(1)) state_next = L_SIGN;
      end
      L_SIGN:  state_next = L_EVAL;
      L_EVAL:  state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      hit   <= 1'b0;
      prev  <= '0;
      last  <= '0;
    end else begin
      state <= state_next;
      case (state)
        L_IDLE: begin
          if (start) done <= 1'b0;
        end
        L_EVAL: begin
          done <= 1'b1;
          hit  <= fire;
          prev <= norm;
          if (fire) last <= now;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          rem  <= i0 ? sub0[15:0] : mag0;
          den  <= den0;
          quo  <= {15'd0, i0};
          neg  <= !ge;
          zero <= den0 == 17'd0;
          cnt  <= CNT_W'(FRAC_BITS);
        end
      end
      L_DIV: begin
        rem <= take ? t_sub[15:0] : t[15:0];
        quo <= {quo[14:0], take};
        cnt <= cnt - CNT_W'(1);
      end
      L_SIGN: begin
        norm <= zero ? 16'sd0 : (neg ? 16'(~quo + 16'd1) : quo);
      end
      default: ;
    endcase
  end

  assign stat.done = done;
  assign stat.hit  = hit;

  `SHK_ASSERT(a_rem_below_den, clk, rst,
    (state == L_DIV && !zero) |-> ({1'b0, rem} < den),
    "divider remainder reached the divisor")
  `SHK_ASSERT(a_quo_in_range, clk, rst,
    (state == L_SIGN && !zero) |-> (quo <= 16'h8000),
    "quotient exceeds full scale")
  `SHK_ASSERT(a_done_clears_on_start, clk, rst,
    ($fell(done) && !$past(rst)) |-> $past(start),
    "done flag dropped without a start")

endmodule
`default_nettype wire

[hw/rtl/shk_merge.sv]
`default_nettype none
module shk_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  shk_pkg::shk_lane_stat_t stat [shk_pkg::AXES],
  input  logic signed [15:0]      norm_in [shk_pkg::AXES],
  output logic                    can_load,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    shake_x,
  output logic                    shake_y,
  output logic                    shake_z,
  output logic signed [15:0]      norm_x,
  output logic signed [15:0]      norm_y,
  output logic signed [15:0]      norm_z
);
  import shk_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shake_x <= stat[0].hit;
      shake_y <= stat[1].hit;
      shake_z <= stat[2].hit;
      norm_x  <= norm_in[0];
      norm_y  <= norm_in[1];
      norm_z  <= norm_in[2];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/three_axis_shake_detector_top.sv]
`default_nettype none
`include "three_axis_shake_detector_top_assert.svh"
// Each sample passes through the lane states divide, sign and evaluate, then loads into the output register.
// A new sample is taken only after the last result is loaded; each axis lane uses a 15-step restoring divider.
// The three axis lanes run in parallel; the output register lets the next sample start early.
// Reset (synchronous, active high) restores the default rest values, threshold and debounce,
// and clears the previous normalized values and the last trigger times to zero.
module three_axis_shake_detector_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  logic        [31:0] time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               shake_x,
  output logic               shake_y,
  output logic               shake_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [15:0] cfg_data
);
  import shk_pkg::*;

  shk_top_state_t state, state_next;

  logic signed [15:0] rest [AXES];
  logic signed [15:0] raw_a [AXES];
  logic signed [15:0] norm_a [AXES];
  shk_lane_stat_t     stat [AXES];
  shk_eval_cfg_t      ecfg;
  logic [31:0]        now;
  logic               lane_start;
  logic               all_done;
  logic               load;
  logic               can_load;

  assign cfg_ready = 1'b1;
  assign raw_a[0]  = raw_x;
  assign raw_a[1]  = raw_y;
  assign raw_a[2]  = raw_z;
  assign all_done  = stat[0].done && stat[1].done && stat[2].done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest[0]        <= REST_X_RST;
      rest[1]        <= REST_Y_RST;
      rest[2]        <= REST_Z_RST;
      ecfg.threshold <= THRESHOLD_RST;
      ecfg.debounce  <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REST_X:    rest[0]        <= cfg_data;
        CFG_REST_Y:    rest[1]        <= cfg_data;
        CFG_REST_Z:    rest[2]        <= cfg_data;
        CFG_THRESHOLD: ecfg.threshold <= cfg_data;
        CFG_DEBOUNCE:  ecfg.debounce  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    lane_start = 1'b0;
    load       = 1'b0;
    case (state)
      T_IDLE: begin
        in_ready   = 1'b1;
        lane_start = in_valid;
        if (in_valid) state_next = T_RUN;
      end
      T_RUN: begin
        if (all_done && can_load) begin
          load       = 1'b1;
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_start) now <= time_ms;
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    shk_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .raw   (raw_a[a]),
      .rest  (rest[a]),
      .now   (now),
      .ecfg  (ecfg),
      .stat  (stat[a]),
      .norm  (norm_a[a])
    );
  end

  shk_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .stat      (stat),
    .norm_in   (norm_a),
    .can_load  (can_load),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .shake_x   (shake_x),
    .shake_y   (shake_y),
    .shake_z   (shake_z),
    .norm_x    (norm_x),
    .norm_y    (norm_y),
    .norm_z    (norm_z)
  );

  `SHK_ASSERT(a_result_after_lanes, clk, rst,
    ($rose(out_valid) && !$past(rst)) |-> $past(all_done),
    "result loaded before all lanes finished")
  `SHK_ASSERT(a_start_clears_done, clk, rst,
    lane_start |=> !all_done,
    "lanes still report done after a new sample started")
  `SHK_ASSERT_ALWAYS(a_reset_empties_output, clk,
    rst |=> !out_valid,
    "output register holds a result after reset")

endmodule
`default_nettype wire
